### src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/ihex_pkg.sv
package ihex_pkg;

  // input operation codes
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  // ascii codes used in the record text
  localparam logic [6:0] CHAR_COLON   = 7'h3A;
  localparam logic [6:0] CHAR_ZERO    = 7'h30;
  localparam logic [6:0] CHAR_ONE     = 7'h31;
  localparam logic [6:0] CHAR_NINE    = 7'h39;
  localparam logic [6:0] CHAR_A       = 7'h41;
  localparam logic [6:0] CHAR_F       = 7'h46;
  localparam logic [6:0] CHAR_NL      = 7'h0A;
  localparam logic [6:0] CHAR_HEX_BIAS = 7'h37;

  // record layout: colon, count, address, type before the data digits
  localparam int HEAD_LEN = 9;
  localparam int EOF_LEN  = 12;

  localparam logic [15:0] START_ADDRESS_RESET = 16'h8000;

  // controller to datapath commands
  typedef struct packed {
    logic write;       // store the accepted data byte
    logic end_stream;  // close the current stream
    logic emit;        // load the next character into the output register
    logic last;        // that character ends the run
    logic eof_sel;     // character comes from the end-of-file record
    logic pos_step;    // advance the character position
    logic pos_clear;   // restart the character position
    logic rec_done;    // data record fully sent
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic active;      // a byte was taken in this stream
    logic fill_zero;   // no bytes pending
    logic full_after;  // the next data byte completes a record
    logic rec_last;    // position is the record newline
    logic eof_last;    // position is the end-of-file newline
    logic out_free;    // output register can take a character
  } dp_status_t;

  // upper-case hex digit
  function automatic logic [6:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) begin
      hex_char = CHAR_ZERO + 7'(n);
    end else begin
      hex_char = CHAR_HEX_BIAS + 7'(n);
    end
  endfunction

  // text of the end-of-file record ":00000001FF\n"
  function automatic logic [6:0] eof_char(input logic [3:0] idx);
    unique case (idx)
      4'd0:    eof_char = CHAR_COLON;
      4'd8:    eof_char = CHAR_ONE;
      4'd9:    eof_char = CHAR_F;
      4'd10:   eof_char = CHAR_F;
      4'd11:   eof_char = CHAR_NL;
      default: eof_char = CHAR_ZERO;
    endcase
  endfunction

endpackage

### src/ihex_in_if.sv
interface ihex_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink (input valid, input op, input data_byte, output ready);
endinterface

### src/ihex_out_if.sv
interface ihex_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last_of_run;

  modport source (output valid, output char_code, output last_of_run, input ready);
  modport sink (input valid, input char_code, input last_of_run, output ready);
endinterface

### src/ihex_datapath.sv
module ihex_datapath #(
  parameter int RECORD_BYTES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_wr_data,
  input  logic [7:0]           in_data,
  input  ihex_pkg::dp_cmd_t    cmd,
  output ihex_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [6:0]           out_char,
  output logic                 out_last
);

  localparam int FILL_W = $clog2(RECORD_BYTES + 1);
  localparam int IDX_W  = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam int POS_W  = $clog2(ihex_pkg::HEAD_LEN + 3 + 2 * RECORD_BYTES);

  logic [15:0]       start_address;
  logic [15:0]       record_address;
  logic [FILL_W-1:0] fill;
  logic [7:0]        data_sum;
  logic              active;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_next;
  logic [7:0]        line_store [RECORD_BYTES];

  logic [FILL_W-1:0] fill_base;
  logic [FILL_W-1:0] fill_inc;
  logic [POS_W-1:0]  dpos;
  logic [POS_W-1:0]  dpos_next;
  logic [POS_W-1:0]  two_cnt;
  logic [IDX_W-1:0]  rd_idx;
  logic [7:0]        rd_byte;
  logic [7:0]        cnt8;
  logic [7:0]        sum8;
  logic [7:0]        checksum;
  logic [6:0]        rec_char;
  logic [6:0]        char_next;

  // fill position as seen by an incoming byte
  assign fill_base = active ? fill : '0;
  assign fill_inc  = fill_base + FILL_W'(1);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= ihex_pkg::START_ADDRESS_RESET;
    end else if (cfg_wr_en) begin
      start_address <= cfg_wr_data;
    end
  end

  // line store, written one byte per data transfer
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      line_store[fill_base[IDX_W-1:0]] <= in_data;
    end
  end

  // stream and record state
  always_ff @(posedge clk) begin
    if (rst) begin
      record_address <= '0;
      fill           <= '0;
      data_sum       <= '0;
      active         <= 1'b0;
    end else begin
      if (cmd.write) begin
        fill   <= fill_inc;
        active <= 1'b1;
        if (!active) begin
          record_address <= start_address;
          data_sum       <= in_data;
        end else begin
          data_sum <= data_sum + in_data;
        end
      end
      if (cmd.end_stream) begin
        active <= 1'b0;
      end
      if (cmd.rec_done) begin
        record_address <= record_address + 16'(fill);
        fill           <= '0;
        data_sum       <= '0;
      end
    end
  end

  // character position within the record being sent
  always_comb begin
    if (cmd.pos_clear) begin
      pos_next = '0;
    end else if (cmd.pos_step) begin
      pos_next = pos + POS_W'(1);
    end else begin
      pos_next = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

  // line store read, addressed by the position of the coming cycle
  assign dpos_next = pos_next - POS_W'(ihex_pkg::HEAD_LEN);
  assign rd_idx    = dpos_next[IDX_W:1];

  always_ff @(posedge clk) begin
    rd_byte <= line_store[rd_idx];
  end

  // record character for the current position
  assign dpos     = pos - POS_W'(ihex_pkg::HEAD_LEN);
  assign two_cnt  = POS_W'({fill, 1'b0});
  assign cnt8     = 8'(fill);
  assign sum8     = cnt8 + record_address[15:8] + record_address[7:0] + data_sum;
  assign checksum = 8'd0 - sum8;

  always_comb begin
    rec_char = ihex_pkg::CHAR_ZERO;
    if (pos < POS_W'(ihex_pkg::HEAD_LEN)) begin
      case (pos)
        POS_W'(0): rec_char = ihex_pkg::CHAR_COLON;
        POS_W'(1): rec_char = ihex_pkg::hex_char(cnt8[7:4]);
        POS_W'(2): rec_char = ihex_pkg::hex_char(cnt8[3:0]);
        POS_W'(3): rec_char = ihex_pkg::hex_char(record_address[15:12]);
        POS_W'(4): rec_char = ihex_pkg::hex_char(record_address[11:8]);
        POS_W'(5): rec_char = ihex_pkg::hex_char(record_address[7:4]);
        POS_W'(6): rec_char = ihex_pkg::hex_char(record_address[3:0]);
        default:   rec_char = ihex_pkg::CHAR_ZERO;
      endcase
    end else if (dpos < two_cnt) begin
      rec_char = dpos[0] ? ihex_pkg::hex_char(rd_byte[3:0])
                         : ihex_pkg::hex_char(rd_byte[7:4]);
    end else if (dpos == two_cnt) begin
      rec_char = ihex_pkg::hex_char(checksum[7:4]);
    end else if (dpos == two_cnt + POS_W'(1)) begin
      rec_char = ihex_pkg::hex_char(checksum[3:0]);
    end else begin
      rec_char = ihex_pkg::CHAR_NL;
    end
  end

  assign char_next = cmd.eof_sel ? ihex_pkg::eof_char(pos[3:0]) : rec_char;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char <= char_next;
      out_last <= cmd.last;
    end
  end

  // status back to the controller
  always_comb begin
    status.active     = active;
    status.fill_zero  = (fill == '0);
    status.full_after = (fill_inc == FILL_W'(RECORD_BYTES));
    status.rec_last   = (pos >= POS_W'(ihex_pkg::HEAD_LEN)) && (dpos == two_cnt + POS_W'(2));
    status.eof_last   = (pos == POS_W'(ihex_pkg::EOF_LEN - 1));
    status.out_free   = !out_valid || out_ready;
  end

endmodule

### src/ihex_ctrl.sv
module ihex_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_op,
  output logic                 in_ready,
  input  ihex_pkg::dp_status_t status,
  output ihex_pkg::dp_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_REC  = 2'd1;
  localparam logic [1:0] S_EOF  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       eof_pending;
  logic       eof_pending_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // sequencing of transfers and character emission
  always_comb begin
    state_next       = state;
    eof_pending_next = eof_pending;
    cmd              = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_op == ihex_pkg::OP_DATA) begin
            cmd.write = 1'b1;
            if (status.full_after) begin
              state_next       = S_REC;
              eof_pending_next = 1'b0;
            end
          end else if (status.active) begin
            cmd.end_stream = 1'b1;
            if (status.fill_zero) begin
              state_next = S_EOF;
            end else begin
              state_next       = S_REC;
              eof_pending_next = 1'b1;
            end
          end
        end
      end
      S_REC: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.pos_step = 1'b1;
          if (status.rec_last) begin
            cmd.rec_done  = 1'b1;
            cmd.pos_clear = 1'b1;
            cmd.last      = !eof_pending;
            state_next    = eof_pending ? S_EOF : S_IDLE;
          end
        end
      end
      S_EOF: begin
        cmd.eof_sel = 1'b1;
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.pos_step = 1'b1;
          if (status.eof_last) begin
            cmd.pos_clear = 1'b1;
            cmd.last      = 1'b1;
            state_next    = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      eof_pending <= 1'b0;
    end else begin
      state       <= state_next;
      eof_pending <= eof_pending_next;
    end
  end

endmodule

### src/intel_hex_record_encoder.sv
// Intel HEX encoder: bytes are gathered into type 00 records of up to RECORD_BYTES bytes
// and sent as upper-case ASCII, one character per cycle while the output is not stalled.
// The byte that fills a record starts the record text, 12 + 2*n characters, during which
// the input is held off. An end transfer sends any partial record, then the 12-character
// end-of-file record, and nothing when no byte was taken since reset or the previous end.
// The start address register loads the first record address of each stream; write it only
// while idle.
module intel_hex_record_encoder #(
  parameter int RECORD_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  ihex_in_if.sink     in_ch,
  ihex_out_if.source  out_ch
);

  ihex_pkg::dp_cmd_t    cmd;
  ihex_pkg::dp_status_t status;
  logic                 in_ready;

  assign in_ch.ready = in_ready;

  // controller
  ihex_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  ihex_datapath #(
    .RECORD_BYTES (RECORD_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_ch.data_byte),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_char    (out_ch.char_code),
    .out_last    (out_ch.last_of_run)
  );

endmodule

### src/ihex_checker.sv
`include "assert_macros.svh"

module ihex_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] char_code,
  input logic       last_of_run
);

  logic       stall;
  logic       run_mid;
  logic       run_end;
  logic [7:0] out_word;
  logic       is_digit;
  logic       is_upper_hex;
  logic       char_ok;
  logic       at_nl;

  // views of the output channel
  assign stall    = out_valid && !out_ready;
  assign run_mid  = out_valid && out_ready && !last_of_run;
  assign run_end  = out_valid && last_of_run;
  assign out_word = {char_code, last_of_run};

  // record alphabet
  assign is_digit     = (char_code >= ihex_pkg::CHAR_ZERO) && (char_code <= ihex_pkg::CHAR_NINE);
  assign is_upper_hex = (char_code >= ihex_pkg::CHAR_A) && (char_code <= ihex_pkg::CHAR_F);
  assign at_nl        = (char_code == ihex_pkg::CHAR_NL);
  assign char_ok      = is_digit || is_upper_hex || at_nl || (char_code == ihex_pkg::CHAR_COLON);

  // a stalled character holds
  `ASSERT_CLK(a_out_hold, stall |=> out_valid && $stable(out_word), "output changed while stalled")

  // input stays closed while a run still has characters to send
  `ASSERT_CLK(a_busy_no_input, run_mid |-> !in_ready, "input open in the middle of a run")

  // only record text characters appear
  `ASSERT_CLK(a_char_set, out_valid |-> char_ok, "character outside the record alphabet")

  // a run ends on a newline
  `ASSERT_CLK(a_last_newline, run_end |-> at_nl, "run ends on a character other than newline")

  // nothing offered straight after reset
  `ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !out_valid, "output valid after reset")

endmodule

bind intel_hex_record_encoder ihex_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .char_code   (out_ch.char_code),
  .last_of_run (out_ch.last_of_run)
);
